// ===== rtl/tts_pkg.sv =====
// tick task scheduler package: field widths, operation and kind codes,
// slot table entry type and configuration register map
// no dependencies
`default_nettype none

package tts_pkg;

    // field widths of the input and result items
    localparam int unsigned OP_W     = 3;
    localparam int unsigned TKIND_W  = 2;
    localparam int unsigned AMOUNT_W = 16;
    localparam int unsigned SIDX_W   = 3;
    localparam int unsigned EVN_W    = 5;
    localparam int unsigned RKIND_W  = 2;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned UPTIME_W = 32;
    localparam int unsigned EVENTS   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_DESTROY  = 3'd1;
    localparam logic [OP_W-1:0] OP_TRIGGER  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;
    localparam logic [OP_W-1:0] OP_SCAN     = 3'd5;

    // task kind requested on register
    localparam logic [TKIND_W-1:0] TK_ALARM  = 2'd0;
    localparam logic [TKIND_W-1:0] TK_TIMER  = 2'd1;
    localparam logic [TKIND_W-1:0] TK_SIGNAL = 2'd2;

    // kind stored in a slot
    localparam logic [1:0] SK_EMPTY  = 2'd0;
    localparam logic [1:0] SK_ALARM  = 2'd1;
    localparam logic [1:0] SK_TIMER  = 2'd2;
    localparam logic [1:0] SK_SIGNAL = 2'd3;

    // result kinds and status
    localparam logic [RKIND_W-1:0] RK_ACK      = 2'd0;
    localparam logic [RKIND_W-1:0] RK_FIRED    = 2'd1;
    localparam logic [RKIND_W-1:0] RK_FINISHED = 2'd2;
    localparam logic [RKIND_W-1:0] RK_RESERVED = 2'd3;
    localparam logic               ST_OK       = 1'b0;
    localparam logic               ST_FAIL     = 1'b1;

    // configuration port: one register per 32-bit word
    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;
    localparam int unsigned REG_IDX_LSB    = 2;
    localparam logic        REG_TICK_EVENT = 1'b0;

    // one slot of the task table
    typedef struct packed {
        logic [1:0]          kind;
        logic [AMOUNT_W-1:0] reload;
        logic [AMOUNT_W-1:0] countdown;
    } t_slot_entry;

endpackage

`default_nettype wire

// ===== rtl/tts_if.sv =====
// valid/ready channels of the tick task scheduler: input item and result item
// depends on tts_pkg
`default_nettype none

interface tts_in_if;
    logic                          valid;
    logic                          ready;
    logic [tts_pkg::OP_W-1:0]      op;
    logic [tts_pkg::TKIND_W-1:0]   task_kind;
    logic [tts_pkg::AMOUNT_W-1:0]  amount;
    logic [tts_pkg::SIDX_W-1:0]    slot_index;
    logic [tts_pkg::EVN_W-1:0]     event_number;

    modport source (output valid, op, task_kind, amount, slot_index, event_number,
                    input ready);
    modport sink   (input valid, op, task_kind, amount, slot_index, event_number,
                    output ready);
endinterface

interface tts_out_if;
    logic                          valid;
    logic                          ready;
    logic [tts_pkg::RKIND_W-1:0]   result_kind;
    logic                          status;
    logic [tts_pkg::SLOT_W-1:0]    slot;
    logic [tts_pkg::UPTIME_W-1:0]  uptime;
    logic                          last;

    modport source (output valid, result_kind, status, slot, uptime, last,
                    input ready);
    modport sink   (input valid, result_kind, status, slot, uptime, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tick_task_scheduler.sv =====
// tick task scheduler top level: slot table memory, event mask, uptime, scan walker
// depends on tts_pkg and the channel interfaces in tts_if.sv
//
// Usage
//   i_in carries one item per valid/ready handshake: register, destroy, trigger,
//   clear, tick or scan. o_out carries result items; last marks the final result
//   of an item. The APB port writes the tick event number (register 0, byte 0).
// Timing and throughput
//   Register, destroy, trigger, clear, tick and unknown ops get a registered
//   acknowledge that shows on o_out the cycle after the item is accepted, and the
//   next item can be taken in that same cycle if the acknowledge is taken.
//   A scan walks the slot table through the single read port of the slot memory,
//   one slot per cycle while o_out is not stalled; one fired result per firing
//   slot, then one finished result. No new item is accepted until the finished
//   result is loaded.
// Stall
//   Results sit in an output register; while it is full and not taken the scan
//   holds its place and no item is accepted.
// Reset
//   Synchronous, active low: all slots empty (per-slot occupancy flops), event mask,
//   uptime and tick event number zero. No memory clearing pass is needed.
`default_nettype none

module tick_task_scheduler #(
    parameter int unsigned SLOTS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    tts_in_if.sink                                   i_in,
    tts_out_if.source                                o_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tts_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [tts_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [tts_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} t_state;

    // control state
    t_state                               r_state, n_state;
    logic [SLOTS-1:0]                     r_occ, n_occ;
    logic [tts_pkg::EVENTS-1:0]           r_event_mask, n_event_mask;
    logic [tts_pkg::UPTIME_W-1:0]         r_tick_count, n_tick_count;
    logic [tts_pkg::EVN_W-1:0]            r_tick_evn, n_tick_evn;
    logic                                 r_ticked, n_ticked;
    logic [CW-1:0]                        r_rd_idx, n_rd_idx;
    logic                                 r_rd_pend, n_rd_pend;
    logic [AW-1:0]                        r_ev_idx, n_ev_idx;
    logic                                 r_out_valid, n_out_valid;

    // result payload
    logic [tts_pkg::RKIND_W-1:0]          r_out_kind, n_out_kind;
    logic                                 r_out_status, n_out_status;
    logic [tts_pkg::SLOT_W-1:0]           r_out_slot, n_out_slot;
    logic                                 r_out_last, n_out_last;
    logic                                 load_out;

    // slot memory
    tts_pkg::t_slot_entry                 r_mem [SLOTS];
    tts_pkg::t_slot_entry                 r_rdata;
    logic                                 mem_we;
    logic [AW-1:0]                        mem_waddr;
    tts_pkg::t_slot_entry                 mem_wdata;
    logic                                 mem_re;
    logic [AW-1:0]                        mem_raddr;

    // handshake and helpers
    logic                                 out_free;
    logic                                 in_fire;
    logic                                 free_found;
    logic [AW-1:0]                        free_idx;
    logic                                 cfg_we;
    logic                                 ev_go;
    logic                                 rd_go;
    logic                                 rd_more;
    logic [1:0]                           ekind;
    logic [tts_pkg::AMOUNT_W-1:0]         cd_dec;
    logic                                 counting;
    logic                                 ev_fire;

    // channel handshakes
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.status      = r_out_status;
    assign o_out.slot        = r_out_slot;
    assign o_out.uptime      = r_tick_count;
    assign o_out.last        = r_out_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite &&
                    (paddr[tts_pkg::REG_IDX_LSB] == tts_pkg::REG_TICK_EVENT);
    assign prdata = (paddr[tts_pkg::REG_IDX_LSB] == tts_pkg::REG_TICK_EVENT) ?
                    {{(tts_pkg::APB_DATA_W - tts_pkg::EVN_W){1'b0}}, r_tick_evn} :
                    '0;

    // lowest empty slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    // scan evaluation of the slot whose data sits in the read register
    assign ekind    = r_occ[r_ev_idx] ? r_rdata.kind : tts_pkg::SK_EMPTY;
    assign cd_dec   = r_rdata.countdown - 1'b1;
    assign counting = ((ekind == tts_pkg::SK_ALARM) || (ekind == tts_pkg::SK_TIMER)) &&
                      r_ticked;
    assign ev_fire  = counting ? (cd_dec == '0) :
                      ((ekind == tts_pkg::SK_SIGNAL) &&
                       r_event_mask[r_rdata.reload[tts_pkg::EVN_W-1:0]]);

    assign ev_go   = (r_state == S_SCAN) && r_rd_pend && out_free;
    assign rd_more = r_rd_idx < CW'(SLOTS);
    assign rd_go   = (r_state == S_SCAN) && (!r_rd_pend || ev_go) && rd_more;

    assign mem_re    = rd_go;
    assign mem_raddr = r_rd_idx[AW-1:0];

    // next state
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_event_mask = r_event_mask;
        n_tick_count = r_tick_count;
        n_tick_evn   = r_tick_evn;
        n_ticked     = r_ticked;
        n_rd_idx     = r_rd_idx;
        n_rd_pend    = r_rd_pend;
        n_ev_idx     = r_ev_idx;
        load_out     = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = r_ev_idx;
        mem_wdata    = r_rdata;

        if (cfg_we) begin
            n_tick_evn = pwdata[tts_pkg::EVN_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // plain acknowledge unless changed below
                    load_out     = 1'b1;
                    n_out_kind   = tts_pkg::RK_ACK;
                    n_out_status = tts_pkg::ST_OK;
                    n_out_slot   = '0;
                    n_out_last   = 1'b1;
                    case (i_in.op)
                        tts_pkg::OP_REGISTER: begin
                            if ((i_in.task_kind > tts_pkg::TK_SIGNAL) || !free_found) begin
                                n_out_status = tts_pkg::ST_FAIL;
                            end else begin
                                n_occ[free_idx]     = 1'b1;
                                mem_we              = 1'b1;
                                mem_waddr           = free_idx;
                                mem_wdata.kind      = i_in.task_kind + 2'd1;
                                mem_wdata.reload    = i_in.amount;
                                mem_wdata.countdown = i_in.amount;
                                n_out_slot          = tts_pkg::SLOT_W'(free_idx);
                            end
                        end
                        tts_pkg::OP_DESTROY: begin
                            if (32'(i_in.slot_index) < SLOTS) begin
                                n_occ[AW'(i_in.slot_index)] = 1'b0;
                            end else begin
                                n_out_status = tts_pkg::ST_FAIL;
                            end
                        end
                        tts_pkg::OP_TRIGGER: begin
                            n_event_mask[i_in.event_number] = 1'b1;
                        end
                        tts_pkg::OP_CLEAR: begin
                            n_event_mask[i_in.event_number] = 1'b0;
                        end
                        tts_pkg::OP_TICK: begin
                            n_tick_count             = r_tick_count + 1'b1;
                            n_event_mask[r_tick_evn] = 1'b1;
                        end
                        tts_pkg::OP_SCAN: begin
                            // consume the tick event and start the walk
                            load_out                 = 1'b0;
                            n_ticked                 = r_event_mask[r_tick_evn];
                            n_event_mask[r_tick_evn] = 1'b0;
                            n_rd_idx                 = '0;
                            n_rd_pend                = 1'b0;
                            n_state                  = S_SCAN;
                        end
                        default: begin
                            n_out_status = tts_pkg::ST_FAIL;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (ev_go) begin
                    // count down and write back; reload or empty on expiry
                    if (counting) begin
                        mem_we              = 1'b1;
                        mem_wdata.countdown = (cd_dec == '0) ? r_rdata.reload : cd_dec;
                        if ((cd_dec == '0) && (ekind == tts_pkg::SK_ALARM)) begin
                            n_occ[r_ev_idx] = 1'b0;
                        end
                    end else if (ev_fire) begin
                        n_event_mask[r_rdata.reload[tts_pkg::EVN_W-1:0]] = 1'b0;
                    end
                    if (ev_fire) begin
                        load_out     = 1'b1;
                        n_out_kind   = tts_pkg::RK_FIRED;
                        n_out_status = tts_pkg::ST_OK;
                        n_out_slot   = tts_pkg::SLOT_W'(r_ev_idx);
                        n_out_last   = 1'b0;
                    end
                end
                // read side of the walk
                if (rd_go) begin
                    n_rd_pend = 1'b1;
                    n_ev_idx  = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else if (ev_go) begin
                    n_rd_pend = 1'b0;
                end
                if (!rd_more && (!r_rd_pend || ev_go)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    n_out_kind   = tts_pkg::RK_FINISHED;
                    n_out_status = tts_pkg::ST_OK;
                    n_out_slot   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_occ        <= '0;
            r_event_mask <= '0;
            r_tick_count <= '0;
            r_tick_evn   <= '0;
            r_ticked     <= 1'b0;
            r_rd_idx     <= '0;
            r_rd_pend    <= 1'b0;
            r_ev_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_event_mask <= n_event_mask;
            r_tick_count <= n_tick_count;
            r_tick_evn   <= n_tick_evn;
            r_ticked     <= n_ticked;
            r_rd_idx     <= n_rd_idx;
            r_rd_pend    <= n_rd_pend;
            r_ev_idx     <= n_ev_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind   <= n_out_kind;
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_last   <= n_out_last;
        end
    end

    // slot table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tts_checker.sv =====
// port-level checks of the tick task scheduler, attached by bind
// depends on tts_pkg and tick_task_scheduler
`default_nettype none

module tts_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic [tts_pkg::OP_W-1:0]          i_in_op,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [tts_pkg::RKIND_W-1:0]       i_out_kind,
    input wire logic                              i_out_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // no item is taken while a result waits
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("item accepted while result stalled");

    // every item other than a scan gets its acknowledge in the next cycle
    a_ack_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op != tts_pkg::OP_SCAN) |=>
        i_out_valid && i_out_last && (i_out_kind == tts_pkg::RK_ACK))
        else $error("missing acknowledge");

    // while a fired result is offered the scan is still running
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("item accepted in the middle of a scan");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_last  (o_out.last)
);

`default_nettype wire
